>>> rtl/core/nrle_pkg.sv
`timescale 1ns / 1ps

package nrle_pkg;

  // Token parser phases: idle waits for a literal or a run flag, the other
  // phases gather the three count nibbles of a run token.
  localparam logic [1:0] PHASE_IDLE = 2'd0;
  localparam logic [1:0] PHASE_CNT0 = 2'd1;
  localparam logic [1:0] PHASE_LAST = 2'd3;

  // A byte yields at most three results: a run that closes on the high
  // nibble gives two, and a literal on the low nibble can add one more.
  localparam int NUM_SLOTS  = 3;
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [1:0]  phase;
    logic [2:0]  val;
    logic [11:0] cnt;
    logic [2:0]  pend;
    logic        half;
  } nrle_state_t;

  typedef struct packed {
    logic [7:0]  data;
    logic [10:0] rep;
  } nrle_res_t;

  typedef struct packed {
    nrle_res_t [NUM_SLOTS-1:0] slot;
    logic [1:0]                cnt;
  } nrle_bundle_t;

  typedef struct packed {
    nrle_state_t st;
    logic [1:0]  n;
    nrle_res_t   r0;
    nrle_res_t   r1;
  } nrle_step_t;

  // Decodes one nibble against the parser state and returns the new state
  // plus up to two results in order.
  function automatic nrle_step_t nrle_take_nibble(input nrle_state_t st,
                                                  input logic [3:0] nib);
    nrle_step_t  s;
    logic [11:0] c;
    logic [2:0]  v;
    s = '0;
    s.st = st;
    c = {st.cnt[7:0], nib};
    v = st.val;
    if (st.phase == PHASE_IDLE) begin
      if (nib[3] == 1'b0) begin
        if (st.half) begin
          s.r0.data = {1'b0, st.pend, 1'b0, nib[2:0]};
          s.r0.rep  = 11'd1;
          s.n       = 2'd1;
          s.st.half = 1'b0;
          s.st.pend = 3'd0;
        end else begin
          s.st.pend = nib[2:0];
          s.st.half = 1'b1;
        end
      end else begin
        s.st.val   = nib[2:0];
        s.st.cnt   = 12'd0;
        s.st.phase = PHASE_CNT0;
      end
    end else if (st.phase == PHASE_LAST) begin
      s.st.phase = PHASE_IDLE;
      s.st.cnt   = 12'd0;
      s.st.val   = 3'd0;
      if (c != 12'd0) begin
        if (st.half) begin
          s.r0.data = {1'b0, st.pend, 1'b0, v};
          s.r0.rep  = 11'd1;
          s.n       = 2'd1;
          s.st.half = 1'b0;
          s.st.pend = 3'd0;
          c         = c - 12'd1;
        end
        if (c >= 12'd2) begin
          if (s.n == 2'd1) begin
            s.r1.data = {1'b0, v, 1'b0, v};
            s.r1.rep  = c[11:1];
          end else begin
            s.r0.data = {1'b0, v, 1'b0, v};
            s.r0.rep  = c[11:1];
          end
          s.n = s.n + 2'd1;
        end
        if (c[0]) begin
          s.st.pend = v;
          s.st.half = 1'b1;
        end
      end
    end else begin
      s.st.cnt   = c;
      s.st.phase = st.phase + 2'd1;
    end
    return s;
  endfunction

endpackage

>>> rtl/core/nibble_rle_decoder.sv
`timescale 1ns / 1ps

// Run-length decoder for 4-bit nibble streams of 3-bit glyph pixels. Each
// input transaction carries one compressed byte, parsed high nibble first: a
// nibble below 8 is a literal pixel, and a nibble of 8 or more opens a run
// whose 12-bit count follows in the next three nibbles. Pixels are packed two
// to a byte, first pixel in the high nibble, and each output transaction is a
// byte with a repeat count, so a whole run costs at most two transactions.
// out_last marks the final output transaction caused by an input byte; a
// byte that only advances the parser produces none. A byte flagged with
// in_glyph_end returns the parser to its reset state after it is decoded,
// dropping any half byte or unfinished run token. The front end decodes a
// whole byte combinationally and takes one byte per cycle while its two-entry
// queue has room; the back end drains the queue through a single output
// register at one transaction per cycle while out_stall is low. A byte
// produces at most three transactions. On the way out, results pass from the
// queue through a held bundle register into the output register.
module nibble_rle_decoder import nrle_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        in_glyph_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [10:0] out_repeat_res,
  output logic        out_last
);

  logic         q_push;
  logic         q_full;
  logic         q_pop;
  logic         q_valid;
  nrle_bundle_t q_in;
  nrle_bundle_t q_out;

  // Parser: classifies nibbles and builds the results of one byte.
  nrle_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_byte      (in_byte),
    .in_glyph_end (in_glyph_end),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_in)
  );

  // Short queue that lets the parser run ahead of a stalled output.
  nrle_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_in),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_data  (q_out)
  );

  // Emitter: hands out the queued results one transaction at a time.
  nrle_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_data         (q_out),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .out_repeat_res (out_repeat_res),
    .out_last       (out_last)
  );

endmodule

>>> rtl/core/nrle_front.sv
`timescale 1ns / 1ps

module nrle_front import nrle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  output logic         in_stall,
  input  logic [7:0]   in_byte,
  input  logic         in_glyph_end,
  input  logic         q_full,
  output logic         q_push,
  output nrle_bundle_t q_data
);

  nrle_state_t state_r, state_nxt;
  nrle_step_t  hi_step, lo_step;
  logic        accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Both nibbles are parsed in the same cycle; the results are packed in
  // order into the low slots of the bundle.
  always_comb begin
    hi_step   = nrle_take_nibble(state_r, in_byte[7:4]);
    lo_step   = nrle_take_nibble(hi_step.st, in_byte[3:0]);
    q_data    = '0;
    q_data.cnt = hi_step.n + lo_step.n;
    case (hi_step.n)
      2'd2: begin
        q_data.slot[0] = hi_step.r0;
        q_data.slot[1] = hi_step.r1;
        q_data.slot[2] = lo_step.r0;
      end
      2'd1: begin
        q_data.slot[0] = hi_step.r0;
        q_data.slot[1] = lo_step.r0;
        q_data.slot[2] = lo_step.r1;
      end
      default: begin
        q_data.slot[0] = lo_step.r0;
        q_data.slot[1] = lo_step.r1;
      end
    endcase
    q_push    = accept && (q_data.cnt != 2'd0);
    state_nxt = state_r;
    if (accept) begin
      state_nxt = in_glyph_end ? '0 : lo_step.st;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> rtl/core/nrle_fifo.sv
`timescale 1ns / 1ps

module nrle_fifo import nrle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  nrle_bundle_t push_data,
  output logic         full,
  input  logic         pop,
  output logic         head_valid,
  output nrle_bundle_t head_data
);

  nrle_bundle_t            mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == FIFO_CNT_W'(FIFO_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("queue read while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == FIFO_CNT_W'($past(count_r) + 1'b1)))
    else $error("queue occupancy did not grow on a lone write");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("queue occupancy out of range");
`endif

endmodule

>>> rtl/core/nrle_back.sv
`timescale 1ns / 1ps

module nrle_back import nrle_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         q_valid,
  input  nrle_bundle_t q_data,
  output logic         q_pop,
  output logic         out_valid,
  input  logic         out_stall,
  output logic [7:0]   out_byte,
  output logic [10:0]  out_repeat_res,
  output logic         out_last
);

  nrle_bundle_t bundle_r, bundle_nxt;
  logic [1:0]   idx_r, idx_nxt;
  logic         out_valid_r, out_valid_nxt;
  nrle_res_t    out_res_r, out_res_nxt;
  logic         out_last_r, out_last_nxt;
  logic         load, have, done;

  assign load = !out_valid_r || !out_stall;
  assign have = (idx_r != bundle_r.cnt);

  always_comb begin
    bundle_nxt    = bundle_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    if (load) begin
      out_valid_nxt = have;
      if (have) begin
        out_res_nxt  = bundle_r.slot[idx_r];
        out_last_nxt = ((idx_r + 2'd1) == bundle_r.cnt);
        idx_nxt      = idx_r + 2'd1;
      end
    end
    // The held bundle is spent once its final result moves to the output
    // register, so the next one can be fetched in that same cycle.
    done = !have || (load && ((idx_r + 2'd1) == bundle_r.cnt));
    if (done && q_valid) begin
      q_pop      = 1'b1;
      bundle_nxt = q_data;
      idx_nxt    = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bundle_r    <= '0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      bundle_r    <= bundle_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_byte       = out_res_r.data;
  assign out_repeat_res = out_res_r.rep;
  assign out_last       = out_last_r;

endmodule
